// ===== rtl/edq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edq_pkg: shared types and constants for the empirical quantile unit
// Field widths, status and command codes, and the controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package edq_pkg;

  localparam int VALUE_W  = 64;
  localparam int WEIGHT_W = 16;
  localparam int LOC_W    = 16;
  localparam int COUNT_W  = 9;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  localparam int DEF_TABLE_DEPTH            = 256;
  localparam int DEF_LOCATION_FRACTION_BITS = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_CLEAR,
    OP_REPORT,
    OP_INS_START,
    OP_INS_CMP,
    OP_INS_PUT,
    OP_Q_MUL,
    OP_Q_WALK,
    OP_LOAD_OUT
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t status;
  } dp_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             weight_zero;
    logic             full;
    logic             empty;
    logic             greater;
    logic             pos_one;
    logic             hit;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/edq_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edq_in_if: command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface edq_in_if;
  import edq_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [VALUE_W-1:0]  entry_value;
  logic [WEIGHT_W-1:0] entry_weight;
  logic [LOC_W-1:0]    location_fraction;

  modport source (output valid, command, entry_value, entry_weight, location_fraction,
                  input ready);
  modport sink   (input valid, command, entry_value, entry_weight, location_fraction,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/edq_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edq_out_if: response channel
// Valid/ready channel carrying one response item.
// ----------------------------------------------------------------------------
interface edq_out_if;
  import edq_pkg::*;

  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  result_value;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, result_value, status, entry_count, input ready);
  modport sink   (input valid, result_value, status, entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/empirical_distribution_quantile_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// empirical_distribution_quantile_unit: sorted weighted table with
// inverse-CDF lookup
// Clear, sorted insert and quantile query on a table of (value, weight)
// entries held in one RAM.
//
//   channel  dir  payload                                              
//   in_ch    in   command, entry_value, entry_weight, location_fraction
//   out_ch   out  result_value, status, entry_count                    
//
// Clear and rejected commands go from decode straight to the response state.
// Insert shifts up k entries (k at most TABLE_DEPTH - 1); query walks the
// entries up to index i, the index found. Both step through the table on
// the single RAM read port, one entry per cycle.
// One item is in work at a time; a finished response waits in the output
// register and the next command is taken meanwhile.
// Reset is synchronous and empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
module empirical_distribution_quantile_unit #(
  parameter int TABLE_DEPTH            = edq_pkg::DEF_TABLE_DEPTH,
  parameter int LOCATION_FRACTION_BITS = edq_pkg::DEF_LOCATION_FRACTION_BITS
) (
  input logic     clk,
  input logic     rst,
  edq_in_if.sink  in_ch,
  edq_out_if.source out_ch
);
  import edq_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;

  edq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl),
    .stat      (stat)
  );

  edq_datapath #(
    .TABLE_DEPTH            (TABLE_DEPTH),
    .LOCATION_FRACTION_BITS (LOCATION_FRACTION_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .stat              (stat),
    .command           (in_ch.command),
    .entry_value       (in_ch.entry_value),
    .entry_weight      (in_ch.entry_weight),
    .location_fraction (in_ch.location_fraction),
    .result_value      (out_ch.result_value),
    .status            (out_ch.status),
    .entry_count       (out_ch.entry_count)
  );

endmodule

`default_nettype wire

// ===== rtl/edq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module edq_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/edq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edq_datapath: table storage, insert shifter and quantile walker
// Holds the sorted entry RAM, count, total weight, threshold multiplier,
// running-weight accumulator and the response registers.
// ----------------------------------------------------------------------------
module edq_datapath #(
  parameter int TABLE_DEPTH            = edq_pkg::DEF_TABLE_DEPTH,
  parameter int LOCATION_FRACTION_BITS = edq_pkg::DEF_LOCATION_FRACTION_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  edq_pkg::dp_ctl_t               ctl,
  output edq_pkg::dp_stat_t              stat,
  input  logic [edq_pkg::CMD_W-1:0]      command,
  input  logic [edq_pkg::VALUE_W-1:0]    entry_value,
  input  logic [edq_pkg::WEIGHT_W-1:0]   entry_weight,
  input  logic [edq_pkg::LOC_W-1:0]      location_fraction,
  output logic [edq_pkg::VALUE_W-1:0]    result_value,
  output logic [edq_pkg::STATUS_W-1:0]   status,
  output logic [edq_pkg::COUNT_W-1:0]    entry_count
);
  import edq_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int TW  = WEIGHT_W + CW;
  localparam int LFB = LOCATION_FRACTION_BITS;
  localparam int THW = LFB + TW;
  localparam int EW  = VALUE_W + WEIGHT_W;

  // latched item
  logic [CMD_W-1:0]    cmd_q;
  logic [VALUE_W-1:0]  value_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [LFB-1:0]      loc_q;

  logic [CW-1:0]       count;
  logic [TW-1:0]       total;
  logic [AW-1:0]       pos;
  logic [AW-1:0]       idx;
  logic [TW-1:0]       running;
  logic [TW-1:0]       running_next;
  logic [THW-1:0]      threshold;
  logic [VALUE_W-1:0]  res_value;
  status_t             res_status;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [EW-1:0]       wdata;
  logic [AW-1:0]       raddr;
  logic [EW-1:0]       rdata;
  logic [VALUE_W-1:0]  rd_value;
  logic [WEIGHT_W-1:0] rd_weight;
  logic                greater;
  logic                hit;

  edq_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_value     = rdata[EW-1:WEIGHT_W];
  assign rd_weight    = rdata[WEIGHT_W-1:0];
  assign running_next = running + TW'(rd_weight);
  assign greater      = rd_value > value_q;
  // stop on the first crossing, or fall back to the last entry
  assign hit = ({running_next, {LFB{1'b0}}} > threshold) ||
               ((CW'(idx) + CW'(1)) == count);

  assign stat.cmd         = cmd_q;
  assign stat.weight_zero = (weight_q == '0);
  assign stat.full        = (count == CW'(TABLE_DEPTH));
  assign stat.empty       = (count == '0);
  assign stat.greater     = greater;
  assign stat.pos_one     = (pos == AW'(1));
  assign stat.hit         = hit;

  // RAM port control; reads run one entry ahead of the compare
  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = {value_q, weight_q};
    raddr = '0;
    unique case (ctl.op)
      OP_INS_START: raddr = count[AW-1:0] - AW'(1);
      OP_INS_CMP: begin
        we    = 1'b1;
        raddr = pos - AW'(2);
        if (greater) begin
          wdata = rdata;
        end
      end
      OP_INS_PUT:   we    = 1'b1;
      OP_Q_WALK:    raddr = idx + AW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else begin
      unique case (ctl.op)
        OP_CLEAR: begin
          count <= '0;
          total <= '0;
        end
        OP_INS_CMP: begin
          if (!greater) begin
            count <= count + CW'(1);
            total <= total + TW'(weight_q);
          end
        end
        OP_INS_PUT: begin
          count <= count + CW'(1);
          total <= total + TW'(weight_q);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LATCH: begin
        cmd_q    <= command;
        value_q  <= entry_value;
        weight_q <= entry_weight;
        loc_q    <= LFB'(location_fraction);
      end
      OP_CLEAR: begin
        res_value  <= '0;
        res_status <= ST_OK;
      end
      OP_REPORT: begin
        res_value  <= '0;
        res_status <= ctl.status;
      end
      OP_INS_START: begin
        pos        <= count[AW-1:0];
        res_value  <= '0;
        res_status <= ST_OK;
      end
      OP_INS_CMP: begin
        if (greater) begin
          pos <= pos - AW'(1);
        end
      end
      OP_Q_MUL: begin
        threshold <= THW'(loc_q) * THW'(total);
        running   <= '0;
        idx       <= '0;
      end
      OP_Q_WALK: begin
        running <= running_next;
        idx     <= idx + AW'(1);
        if (hit) begin
          res_value  <= rd_value;
          res_status <= ST_OK;
        end
      end
      OP_LOAD_OUT: begin
        result_value <= res_value;
        status       <= res_status;
        entry_count  <= COUNT_W'(count);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/edq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edq_ctrl: command sequencer
// Decodes each accepted item, steps the datapath through the insert
// shift or quantile walk, and owns the response valid flag.
// ----------------------------------------------------------------------------
module edq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output edq_pkg::dp_ctl_t  ctl,
  input  edq_pkg::dp_stat_t stat
);
  import edq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_CMP,
    S_INS_PUT,
    S_Q_WALK,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    ctl.op     = OP_NONE;
    ctl.status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op     = OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_RESP;
        unique case (stat.cmd)
          CMD_CLEAR: ctl.op = OP_CLEAR;
          CMD_INSERT: begin
            if (stat.weight_zero) begin
              ctl.op     = OP_REPORT;
              ctl.status = ST_ZERO;
            end else if (stat.full) begin
              ctl.op     = OP_REPORT;
              ctl.status = ST_FULL;
            end else begin
              ctl.op     = OP_INS_START;
              state_next = stat.empty ? S_INS_PUT : S_INS_CMP;
            end
          end
          CMD_QUERY: begin
            if (stat.empty) begin
              ctl.op     = OP_REPORT;
              ctl.status = ST_EMPTY;
            end else begin
              ctl.op     = OP_Q_MUL;
              state_next = S_Q_WALK;
            end
          end
          default: ctl.op = OP_REPORT;
        endcase
      end
      S_INS_CMP: begin
        ctl.op = OP_INS_CMP;
        if (!stat.greater) begin
          state_next = S_RESP;
        end else if (stat.pos_one) begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        ctl.op     = OP_INS_PUT;
        state_next = S_RESP;
      end
      S_Q_WALK: begin
        ctl.op = OP_Q_WALK;
        if (stat.hit) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          ctl.op     = OP_LOAD_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.op == OP_LOAD_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/edq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edq_checker: port-level checks for the quantile unit
// Watches the response channel; bound to the top level below.
// ----------------------------------------------------------------------------
module edq_checker #(
  parameter int TABLE_DEPTH = edq_pkg::DEF_TABLE_DEPTH
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [edq_pkg::VALUE_W-1:0]    result_value,
  input logic [edq_pkg::STATUS_W-1:0]   status,
  input logic [edq_pkg::COUNT_W-1:0]    entry_count
);
  import edq_pkg::*;

  // a stalled response holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) &&
    $stable(status) && $stable(entry_count))
    else $error("response changed while stalled");

  // reset drops any pending response
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("response valid after reset");

  // an empty-table answer carries a zero value and a zero count
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> (result_value == '0) && (entry_count == '0))
    else $error("empty status with data");

  // rejected inserts return no value, and a full table reports the depth
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_ZERO) |->
    (result_value == '0) &&
    ((status == ST_ZERO) || (TABLE_DEPTH > 511) || (int'(entry_count) == TABLE_DEPTH)))
    else $error("rejected insert reported wrongly");

endmodule

bind empirical_distribution_quantile_unit edq_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_edq_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .result_value (out_ch.result_value),
  .status       (out_ch.status),
  .entry_count  (out_ch.entry_count)
);

`default_nettype wire
